[sv/itsp_pkg.sv]
// Shared codes and types for the indexed texture stream parser.
`timescale 1ns / 1ps
`default_nettype none

package itsp_pkg;

    // Parser phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PALETTE = 3'd1;
    localparam logic [2:0] PH_SIZE    = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_PIXELS  = 3'd4;
    localparam logic [2:0] PH_PACKED  = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    // Header byte positions
    localparam logic [2:0] HDR_ALPHA  = 3'd3;
    localparam logic [2:0] HDR_PACKED = 3'd4;
    localparam logic [2:0] HDR_COUNT  = 3'd5;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ENTRY     = 2'd0,
        KIND_SIZE      = 2'd1,
        KIND_PIXEL     = 2'd2,
        KIND_TRUNCATED = 2'd3
    } kind_t;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam logic [31:0] PIXEL_SAT    = 32'hFFFF_FFFF;

    // One result request
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  entry_number;
        logic [31:0] entry_color;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        logic [7:0]  pixel_value;
        logic [31:0] pixel_number;
        logic        final_item;
    } result_t;

endpackage

`default_nettype wire

[sv/indexed_texture_stream_parser.sv]
// Top level of the indexed texture stream parser: byte parser with a result register.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Feed the texture file one byte per request on the byte channel
//   (byte_valid / byte_stall, data_byte, end_of_file on the last byte).
//   Results leave on the result channel (result_valid / result_stall):
//   one per palette entry, one size record on the low height byte, one per
//   pixel index byte, or a truncated error if the file ends early.
//   A result is registered: it appears in the cycle after the byte that causes it.
//   Throughput: one byte per cycle while byte_stall is low; each byte updates only counters and
//   small registers, and the size product is one 16x16 multiply in the
//   cycle of the low height byte.
//   A single result register parts the channels: while it holds a result
//   and result_stall is high, byte_stall is high and the parser holds.
//   Otherwise a new byte is taken in the same cycle the old result leaves.
//   Reset (rst_n low, asynchronous) returns the parser to the header phase
//   and empties the result register. After the end_of_file byte the parser
//   returns to that same state, ready for the next file.
module indexed_texture_stream_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 end_of_file,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output itsp_pkg::kind_t           kind,
    output logic [7:0]                entry_number,
    output logic [31:0]               entry_color,
    output logic [15:0]               image_width,
    output logic [15:0]               image_height,
    output logic                      has_alpha,
    output logic [7:0]                pixel_value,
    output logic [31:0]               pixel_number,
    output logic                      final_item
);
    import itsp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  offset_reg, offset_next;
    logic        alpha_reg, alpha_next;
    logic        packed_reg, packed_next;
    logic [7:0]  ent_total_reg, ent_total_next;
    logic [7:0]  ent_done_reg, ent_done_next;
    logic [1:0]  step_reg, step_next;
    logic [31:0] gather_reg, gather_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] pix_done_reg, pix_done_next;
    logic [31:0] pix_total_reg, pix_total_next;

    logic        res_valid_reg;
    result_t     res_reg;
    result_t     res_comb;
    logic        res_fire;
    logic        accept;
    logic        load;

    logic [1:0]  entry_last;
    logic [7:0]  ent_done_inc;
    logic [31:0] pix_done_inc;
    logic        pix_last;
    logic [15:0] height_low;
    logic [31:0] size_product;

    // Take a byte whenever the result register is free or draining
    assign load       = !res_valid_reg || !result_stall;
    assign byte_stall = !load;
    assign accept     = byte_valid && load;

    assign entry_last   = alpha_reg ? 2'd3 : 2'd2;
    assign ent_done_inc = ent_done_reg + 8'd1;
    assign pix_last     = ((pix_done_reg + 32'd1) == pix_total_reg);
    assign pix_done_inc = (pix_done_reg != PIXEL_SAT) ? pix_done_reg + 32'd1 : pix_done_reg;
    assign height_low   = {height_reg[15:8], data_byte};
    assign size_product = {16'd0, width_reg} * {16'd0, height_low};

    // Parse one byte
    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        alpha_next     = alpha_reg;
        packed_next    = packed_reg;
        ent_total_next = ent_total_reg;
        ent_done_next  = ent_done_reg;
        step_next      = step_reg;
        gather_next    = gather_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        pix_done_next  = pix_done_reg;
        pix_total_next = pix_total_reg;
        res_fire       = 1'b0;
        res_comb       = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == HDR_ALPHA)
                    begin
                        alpha_next = (data_byte == 8'd1);
                    end
                    else if (offset_reg == HDR_PACKED)
                    begin
                        packed_next = (data_byte == 8'd1);
                    end
                    else if (offset_reg == HDR_COUNT)
                    begin
                        ent_total_next = data_byte;
                        ent_done_next  = 8'd0;
                        step_next      = 2'd0;
                        gather_next    = 32'd0;
                    end
                    if (offset_reg >= HDR_COUNT)
                    begin
                        offset_next = 3'd0;
                        step_next   = 2'd0;
                        phase_next  = (ent_total_next != 8'd0) ? PH_PALETTE : PH_SIZE;
                    end
                    else
                    begin
                        offset_next = offset_reg + 3'd1;
                    end
                end
                PH_PALETTE:
                begin
                    // Gather alpha into the top byte, shift color bytes in below
                    if (alpha_reg && (step_reg == 2'd0))
                        gather_next = {data_byte, 24'd0};
                    else
                        gather_next = {gather_reg[31:24], gather_reg[15:0], data_byte};
                    if (step_reg >= entry_last)
                    begin
                        res_fire              = 1'b1;
                        res_comb.kind         = KIND_ENTRY;
                        res_comb.entry_number = ent_done_reg;
                        res_comb.has_alpha    = alpha_reg;
                        if (alpha_reg && (gather_next[31:24] == 8'd0))
                            res_comb.entry_color = 32'd0;
                        else
                            res_comb.entry_color = ALPHA_OPAQUE | {8'd0, gather_next[23:0]};
                        step_next     = 2'd0;
                        gather_next   = 32'd0;
                        ent_done_next = ent_done_inc;
                        if (ent_done_inc == ent_total_reg)
                            phase_next = PH_SIZE;
                    end
                    else
                    begin
                        step_next = step_reg + 2'd1;
                    end
                end
                PH_SIZE:
                begin
                    unique case (step_reg)
                        2'd0:    width_next  = {data_byte, width_reg[7:0]};
                        2'd1:    width_next  = {width_reg[15:8], data_byte};
                        2'd2:    height_next = {data_byte, height_reg[7:0]};
                        default: height_next = height_low;
                    endcase
                    if (step_reg == 2'd3)
                    begin
                        pix_total_next        = size_product;
                        pix_done_next         = 32'd0;
                        res_fire              = 1'b1;
                        res_comb.kind         = KIND_SIZE;
                        res_comb.image_width  = width_reg;
                        res_comb.image_height = height_low;
                        res_comb.has_alpha    = alpha_reg;
                        step_next             = 2'd0;
                        phase_next            = PH_SKIP;
                    end
                    else
                    begin
                        step_next = step_reg + 2'd1;
                    end
                end
                PH_SKIP:
                begin
                    priority if (packed_reg)
                        phase_next = PH_PACKED;
                    else if (pix_total_reg == 32'd0)
                        phase_next = PH_DONE;
                    else
                        phase_next = PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    res_fire              = 1'b1;
                    res_comb.kind         = KIND_PIXEL;
                    res_comb.has_alpha    = alpha_reg;
                    res_comb.pixel_value  = data_byte;
                    res_comb.pixel_number = pix_done_reg;
                    res_comb.final_item   = pix_last;
                    pix_done_next         = pix_done_inc;
                    if (pix_last || (pix_done_inc >= pix_total_reg))
                        phase_next = PH_DONE;
                end
                default:
                begin
                    // Packed run, done or unused code: drop the byte
                end
            endcase

            // End of file: flag truncation unless finished, then start over
            if (end_of_file)
            begin
                if ((phase_next != PH_DONE) && (phase_next != PH_PACKED))
                begin
                    res_fire            = 1'b1;
                    res_comb            = '0;
                    res_comb.kind       = KIND_TRUNCATED;
                    res_comb.final_item = 1'b1;
                end
                phase_next     = PH_HEADER;
                offset_next    = 3'd0;
                alpha_next     = 1'b0;
                packed_next    = 1'b0;
                ent_total_next = 8'd0;
                ent_done_next  = 8'd0;
                step_next      = 2'd0;
                gather_next    = 32'd0;
                width_next     = 16'd0;
                height_next    = 16'd0;
                pix_done_next  = 32'd0;
                pix_total_next = 32'd0;
            end
        end
    end

    // Advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            offset_reg    <= 3'd0;
            alpha_reg     <= 1'b0;
            packed_reg    <= 1'b0;
            ent_total_reg <= 8'd0;
            ent_done_reg  <= 8'd0;
            step_reg      <= 2'd0;
            gather_reg    <= 32'd0;
            width_reg     <= 16'd0;
            height_reg    <= 16'd0;
            pix_done_reg  <= 32'd0;
            pix_total_reg <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            alpha_reg     <= alpha_next;
            packed_reg    <= packed_next;
            ent_total_reg <= ent_total_next;
            ent_done_reg  <= ent_done_next;
            step_reg      <= step_next;
            gather_reg    <= gather_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            pix_done_reg  <= pix_done_next;
            pix_total_reg <= pix_total_next;
        end
    end

    // Hold the result valid until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            res_valid_reg <= res_fire;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (load && res_fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign result_valid = res_valid_reg;
    assign kind         = res_reg.kind;
    assign entry_number = res_reg.entry_number;
    assign entry_color  = res_reg.entry_color;
    assign image_width  = res_reg.image_width;
    assign image_height = res_reg.image_height;
    assign has_alpha    = res_reg.has_alpha;
    assign pixel_value  = res_reg.pixel_value;
    assign pixel_number = res_reg.pixel_number;
    assign final_item   = res_reg.final_item;

endmodule

`default_nettype wire

[test/tb_indexed_texture_stream_parser.sv]
// Testbench for the indexed texture stream parser: directed and random texture files.
`timescale 1ns / 1ps

module tb_indexed_texture_stream_parser;
    import itsp_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_CAP  = 40;
    localparam int DRAIN_WAIT  = 8;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte    = 8'h00;
    logic        end_of_file  = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    kind_t       kind;
    logic [7:0]  entry_number;
    logic [31:0] entry_color;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic [7:0]  pixel_value;
    logic [31:0] pixel_number;
    logic        final_item;

    // Parser state as the testbench tracks it
    logic [2:0]  tp_phase;
    logic [2:0]  tp_hdr_pos;
    logic        tp_alpha;
    logic        tp_packed;
    logic [7:0]  tp_entry_count;
    logic [7:0]  tp_entry_idx;
    logic [1:0]  tp_step;
    logic [31:0] tp_color;
    logic [15:0] tp_width;
    logic [15:0] tp_height;
    logic [31:0] tp_pix_idx;
    logic [31:0] tp_pix_total;

    result_t     awaited_records[$];
    logic [7:0]  texture_bytes[$];

    bit          tx_idling = 1'b0;
    bit          rx_idling = 1'b0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          records_checked = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          kinds_seen[4] = '{0, 0, 0, 0};

    indexed_texture_stream_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_file  (end_of_file),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .entry_number (entry_number),
        .entry_color  (entry_color),
        .image_width  (image_width),
        .image_height (image_height),
        .has_alpha    (has_alpha),
        .pixel_value  (pixel_value),
        .pixel_number (pixel_number),
        .final_item   (final_item)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Return the tracked state to its after-reset values
    task automatic clear_texture_state();
        tp_phase       = PH_HEADER;
        tp_hdr_pos     = 3'd0;
        tp_alpha       = 1'b0;
        tp_packed      = 1'b0;
        tp_entry_count = 8'd0;
        tp_entry_idx   = 8'd0;
        tp_step        = 2'd0;
        tp_color       = 32'd0;
        tp_width       = 16'd0;
        tp_height      = 16'd0;
        tp_pix_idx     = 32'd0;
        tp_pix_total   = 32'd0;
    endtask

    // Advance the tracked parser by one accepted byte and queue the record it yields
    task automatic parse_texture_byte(input logic [7:0] b, input logic eof);
        result_t rec;
        logic    emit;
        logic    is_last;
        rec  = '0;
        emit = 1'b0;
        case (tp_phase)
            PH_HEADER:
            begin
                if (tp_hdr_pos == HDR_ALPHA)
                    tp_alpha = (b == 8'd1);
                else if (tp_hdr_pos == HDR_PACKED)
                    tp_packed = (b == 8'd1);
                else if (tp_hdr_pos == HDR_COUNT)
                begin
                    tp_entry_count = b;
                    tp_entry_idx   = 8'd0;
                    tp_step        = 2'd0;
                    tp_color       = 32'd0;
                end
                if (tp_hdr_pos >= HDR_COUNT)
                begin
                    tp_hdr_pos = 3'd0;
                    tp_step    = 2'd0;
                    tp_phase   = (tp_entry_count != 8'd0) ? PH_PALETTE : PH_SIZE;
                end
                else
                    tp_hdr_pos = tp_hdr_pos + 3'd1;
            end
            PH_PALETTE:
            begin
                // gather color bytes; the alpha byte lands in the top byte
                if (tp_alpha && tp_step == 2'd0)
                    tp_color = {b, 24'h0};
                else
                    tp_color = {tp_color[31:24], tp_color[15:0], b};
                if (tp_step >= (tp_alpha ? 2'd3 : 2'd2))
                begin
                    emit             = 1'b1;
                    rec.kind         = KIND_ENTRY;
                    rec.entry_number = tp_entry_idx;
                    rec.entry_color  = (!tp_alpha || tp_color[31:24] != 8'd0) ?
                                       (ALPHA_OPAQUE | {8'h00, tp_color[23:0]}) : 32'd0;
                    rec.has_alpha    = tp_alpha;
                    tp_step          = 2'd0;
                    tp_color         = 32'd0;
                    tp_entry_idx     = tp_entry_idx + 8'd1;
                    if (tp_entry_idx == tp_entry_count)
                        tp_phase = PH_SIZE;
                end
                else
                    tp_step = tp_step + 2'd1;
            end
            PH_SIZE:
            begin
                case (tp_step)
                    2'd0: tp_width[15:8]  = b;
                    2'd1: tp_width[7:0]   = b;
                    2'd2: tp_height[15:8] = b;
                    default: tp_height[7:0] = b;
                endcase
                if (tp_step == 2'd3)
                begin
                    tp_pix_total     = {16'h0, tp_width} * {16'h0, tp_height};
                    tp_pix_idx       = 32'd0;
                    emit             = 1'b1;
                    rec.kind         = KIND_SIZE;
                    rec.image_width  = tp_width;
                    rec.image_height = tp_height;
                    rec.has_alpha    = tp_alpha;
                    tp_step          = 2'd0;
                    tp_phase         = PH_SKIP;
                end
                else
                    tp_step = tp_step + 2'd1;
            end
            PH_SKIP:
            begin
                if (tp_packed)
                    tp_phase = PH_PACKED;
                else if (tp_pix_total == 32'd0)
                    tp_phase = PH_DONE;
                else
                    tp_phase = PH_PIXELS;
            end
            PH_PIXELS:
            begin
                is_last          = ((tp_pix_idx + 32'd1) == tp_pix_total);
                emit             = 1'b1;
                rec.kind         = KIND_PIXEL;
                rec.has_alpha    = tp_alpha;
                rec.pixel_value  = b;
                rec.pixel_number = tp_pix_idx;
                rec.final_item   = is_last;
                if (tp_pix_idx != PIXEL_SAT)
                    tp_pix_idx = tp_pix_idx + 32'd1;
                if (is_last || tp_pix_idx >= tp_pix_total)
                    tp_phase = PH_DONE;
            end
            default:
            begin
                // packed run or done: drop the byte
            end
        endcase
        // an early end replaces whatever the byte produced
        if (eof)
        begin
            if (tp_phase != PH_DONE && tp_phase != PH_PACKED)
            begin
                rec            = '0;
                rec.kind       = KIND_TRUNCATED;
                rec.final_item = 1'b1;
                emit           = 1'b1;
            end
            clear_texture_state();
        end
        if (emit)
            awaited_records.push_back(rec);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                     $realtime, field, records_checked, got, want);
    endtask

    // Send one request and track it once the parser takes it
    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (tx_idling && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        byte_valid  <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        parse_texture_byte(b, eof);
        bytes_sent++;
    endtask

    // Send the assembled file, marking its last byte as the end
    task automatic send_texture();
        foreach (texture_bytes[i])
            send_byte(texture_bytes[i], i == texture_bytes.size() - 1);
        texture_bytes.delete();
        files_sent++;
    endtask

    task automatic push_random(input int n);
        repeat (n) texture_bytes.push_back(8'($urandom));
    endtask

    task automatic push_header(input logic [7:0] alpha_flag, input logic [7:0] packed_flag,
                               input logic [7:0] count);
        push_random(3);
        texture_bytes.push_back(alpha_flag);
        texture_bytes.push_back(packed_flag);
        texture_bytes.push_back(count);
    endtask

    task automatic push_palette(input logic alpha, input int count);
        repeat (count)
        begin
            // transparent entries about a third of the time
            if (alpha)
                texture_bytes.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
            push_random(3);
        end
    endtask

    task automatic push_size_and_skip(input logic [15:0] w, input logic [15:0] h);
        texture_bytes.push_back(w[15:8]);
        texture_bytes.push_back(w[7:0]);
        texture_bytes.push_back(h[15:8]);
        texture_bytes.push_back(h[7:0]);
        push_random(1);
    endtask

    // Build one random file: mostly well formed, some cut short or padded
    task automatic push_random_texture();
        logic [7:0]  alpha_flag;
        logic [7:0]  packed_flag;
        logic [7:0]  count;
        logic [15:0] w;
        logic [15:0] h;
        int          shape;
        int          cut;
        case ($urandom_range(0, 5))
            0: alpha_flag = 8'($urandom);
            1, 2: alpha_flag = 8'd0;
            default: alpha_flag = 8'd1;
        endcase
        if ($urandom_range(0, 7) == 0)
            packed_flag = 8'd1;
        else if ($urandom_range(0, 7) == 0)
            packed_flag = 8'($urandom);
        else
            packed_flag = 8'd0;
        count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40)) :
                                              8'($urandom_range(0, 6));
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 6));
        // empty image with a wide dimension on the other side
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                w = 16'($urandom);
                h = 16'd0;
            end
            else
            begin
                w = 16'd0;
                h = 16'($urandom);
            end
        end
        push_header(alpha_flag, packed_flag, count);
        push_palette(alpha_flag == 8'd1, count);
        push_size_and_skip(w, h);
        if (packed_flag == 8'd1)
            push_random($urandom_range(0, 8));
        else
            push_random(int'(w) * int'(h));
        shape = $urandom_range(0, 9);
        if (shape < 2)
        begin
            cut = $urandom_range(1, texture_bytes.size() - 1);
            repeat (cut) texture_bytes.delete(texture_bytes.size() - 1);
        end
        else if (shape == 2)
            push_random($urandom_range(1, 4));
    endtask

    task automatic test_palettes();
        logic [31:0] argb_words[3];
        argb_words = '{32'h0012_3456, 32'hFF00_0000, 32'h01AB_CDEF};
        // RGB entries at both extremes
        push_header(8'd0, 8'd0, 8'd2);
        for (int i = 0; i < 6; i++)
            texture_bytes.push_back((i < 3) ? 8'h00 : 8'hFF);
        push_size_and_skip(16'd1, 16'd2);
        texture_bytes.push_back(8'h00);
        texture_bytes.push_back(8'hFF);
        send_texture();
        // ARGB entries: transparent, opaque black, low nonzero alpha
        push_header(8'd1, 8'd0, 8'd3);
        foreach (argb_words[i])
            for (int k = 3; k >= 0; k--)
                texture_bytes.push_back(argb_words[i][8 * k +: 8]);
        push_size_and_skip(16'd2, 16'd1);
        push_random(2);
        send_texture();
    endtask

    task automatic test_empty_palette();
        push_header(8'd0, 8'd0, 8'd0);
        push_size_and_skip(16'd3, 16'd1);
        push_random(3);
        send_texture();
    endtask

    task automatic test_empty_image();
        push_header(8'd1, 8'd0, 8'd1);
        push_palette(1'b1, 1);
        push_size_and_skip(16'hFFFF, 16'd0);
        send_texture();
        push_header(8'd0, 8'd0, 8'd0);
        push_size_and_skip(16'd0, 16'hFFFF);
        send_texture();
    endtask

    task automatic test_packed_mode();
        push_header(8'd0, 8'd1, 8'd1);
        push_palette(1'b0, 1);
        push_size_and_skip(16'd4, 16'd4);
        push_random(5);
        send_texture();
        // end right on the skip byte
        push_header(8'd1, 8'd1, 8'd0);
        push_size_and_skip(16'd0, 16'd0);
        send_texture();
    endtask

    task automatic test_trailing_bytes();
        push_header(8'd0, 8'd0, 8'd1);
        push_palette(1'b0, 1);
        push_size_and_skip(16'd1, 16'd1);
        push_random(4);
        send_texture();
    endtask

    task automatic test_truncation();
        // inside the header
        push_random(3);
        send_texture();
        // inside the palette
        push_header(8'd1, 8'd0, 8'd2);
        push_random(5);
        send_texture();
        // on the high height byte
        push_header(8'd0, 8'd0, 8'd0);
        push_random(3);
        send_texture();
        // on the skip byte with pixels pending
        push_header(8'd0, 8'd0, 8'd0);
        push_size_and_skip(16'd1, 16'd1);
        send_texture();
        // inside the pixels
        push_header(8'd0, 8'd0, 8'd0);
        push_size_and_skip(16'd2, 16'd2);
        push_random(2);
        send_texture();
    endtask

    task automatic test_odd_flags();
        push_header(8'd2, 8'hFF, 8'd1);
        push_palette(1'b0, 1);
        push_size_and_skip(16'd1, 16'd1);
        push_random(1);
        send_texture();
        push_header(8'hFF, 8'd2, 8'd0);
        push_size_and_skip(16'd2, 16'd1);
        push_random(2);
        send_texture();
    endtask

    task automatic test_full_palette();
        push_header(8'd0, 8'd0, 8'd255);
        push_palette(1'b0, 255);
        push_size_and_skip(16'd1, 16'd1);
        push_random(1);
        send_texture();
    endtask

    task automatic test_random_files(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            push_random_texture();
            send_texture();
        end
    endtask

    // Raw bytes with random file ends, closed by an end so the next file starts clean
    task automatic test_random_noise(input int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            send_byte(8'($urandom), ($urandom_range(0, 39) == 0) || (i == n_bytes - 1));
        files_sent++;
    endtask

    // Result receiver: stall in random bursts while idling is enabled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (rx_idling && $urandom_range(0, 4) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 5);
        end
        else
            result_stall <= 1'b0;
    end

    // Compare each accepted result with the oldest expected record
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_records.size() == 0)
                report_mismatch("unexpected result, kind", 32'(kind), 32'd0);
            else
            begin
                want = awaited_records.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (entry_number !== want.entry_number)
                    report_mismatch("entry_number", 32'(entry_number), 32'(want.entry_number));
                if (entry_color !== want.entry_color)
                    report_mismatch("entry_color", entry_color, want.entry_color);
                if (image_width !== want.image_width)
                    report_mismatch("image_width", 32'(image_width), 32'(want.image_width));
                if (image_height !== want.image_height)
                    report_mismatch("image_height", 32'(image_height), 32'(want.image_height));
                if (has_alpha !== want.has_alpha)
                    report_mismatch("has_alpha", 32'(has_alpha), 32'(want.has_alpha));
                if (pixel_value !== want.pixel_value)
                    report_mismatch("pixel_value", 32'(pixel_value), 32'(want.pixel_value));
                if (pixel_number !== want.pixel_number)
                    report_mismatch("pixel_number", pixel_number, want.pixel_number);
                if (final_item !== want.final_item)
                    report_mismatch("final_item", 32'(final_item), 32'(want.final_item));
                kinds_seen[want.kind]++;
            end
            records_checked++;
        end
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, awaited_records.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_texture_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_palettes();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        test_empty_palette();
        test_empty_image();
        test_packed_mode();
        test_trailing_bytes();
        test_truncation();
        test_odd_flags();
        test_full_palette();
        test_random_files(120);
        test_random_noise(40);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        test_random_files(60);

        // drain outstanding results, then let the pipeline settle
        byte_valid <= 1'b0;
        while (awaited_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d bytes in %0d files; checked %0d results:", bytes_sent,
                 files_sent, records_checked);
        $display("  %0d palette entries, %0d size records, %0d pixels, %0d truncations",
                 kinds_seen[KIND_ENTRY], kinds_seen[KIND_SIZE], kinds_seen[KIND_PIXEL],
                 kinds_seen[KIND_TRUNCATED]);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/itsp_pkg.sv
sv/indexed_texture_stream_parser.sv
test/tb_indexed_texture_stream_parser.sv
